### sv/pfr_pkg.sv
// Package for the page frame replacement block: payload structs, policy codes,
// controller/datapath command and status structs. No dependencies.
package pfr_pkg;

	localparam int unsigned FrameW = 4;
	localparam int unsigned ProcW  = 2;
	localparam int unsigned PageW  = 6;
	localparam int unsigned TimeW  = 32;
	localparam int unsigned RndW   = 31;

	localparam logic [1:0] POL_LIFO   = 2'd0;
	localparam logic [1:0] POL_RANDOM = 2'd1;
	localparam logic [1:0] POL_LRU    = 2'd2;

	localparam logic CFG_POLICY = 1'b0;
	localparam logic CFG_FRAMES = 1'b1;

	typedef struct packed {
		logic [1:0]  process_id;
		logic [5:0]  page_no;
		logic [30:0] random_value;
	} pfr_in_t;

	typedef struct packed {
		logic        hit;
		logic [3:0]  frame_index;
		logic        evicted;
		logic [1:0]  victim_process;
		logic [5:0]  victim_page;
		logic [31:0] residency;
	} pfr_out_t;

	typedef struct packed {
		logic [1:0] index;
		logic [4:0] data;
	} pfr_cfg_t;

	// controller -> datapath
	typedef struct packed {
		logic load;       // latch input, bump time, read map
		logic scan_start; // start free/LRU scan
		logic scan_step;
		logic rem_step;   // one restoring step of rnd mod count
		logic commit;     // write state, build result
	} pfr_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic hit;
		logic scan_done;
		logic free_found;
		logic rem_done;
	} pfr_sts_t;

endpackage

### sv/pfr_ram.sv
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module pfr_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

### sv/pfr_ctrl.sv
// Controller state machine for the page frame replacement block.
// Depends on pfr_pkg.
module pfr_ctrl import pfr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	input  logic [1:0] policy,
	output pfr_cmd_t cmd,
	input  pfr_sts_t sts
);
	typedef enum logic [7:0] {
		S_IDLE = 8'b00000001,
		S_LOOK = 8'b00000010,
		S_SCAN = 8'b00000100,
		S_REM  = 8'b00001000,
		S_VRD  = 8'b00010000,
		S_VWT  = 8'b00100000,
		S_COMM = 8'b01000000,
		S_OUT  = 8'b10000000
	} state_t;

	state_t state_q, state_d;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_LOOK;
				end
			end
			S_LOOK: begin
				// map read data valid this cycle
				if (sts.hit) begin
					state_d = S_COMM;
				end else begin
					cmd.scan_start = 1'b1;
					state_d        = S_SCAN;
				end
			end
			S_SCAN: begin
				if (sts.scan_done) begin
					if (sts.free_found) begin
						state_d = S_COMM;
					end else if (policy == POL_RANDOM) begin
						state_d = S_REM;
					end else begin
						state_d = S_VRD;
					end
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			S_REM: begin
				if (sts.rem_done) begin
					state_d = S_VRD;
				end else begin
					cmd.rem_step = 1'b1;
				end
			end
			// victim frame is final: its load time is read in these cycles
			S_VRD: state_d = S_VWT;
			S_VWT: state_d = S_COMM;
			S_COMM: begin
				cmd.commit = 1'b1;
				state_d    = S_OUT;
			end
			S_OUT: begin
				if (!out_stall) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

### sv/pfr_dp.sv
// Datapath: frame table, page map, scans, victim selection and result register.
// Depends on pfr_pkg and pfr_ram.
module pfr_dp import pfr_pkg::*; #(
	parameter int unsigned MAX_FRAMES        = 16,
	parameter int unsigned PAGES_PER_PROCESS = 64,
	parameter int unsigned PROCESSES         = 4
) (
	input  logic     clk,
	input  logic     arst_n,
	input  pfr_in_t  in_item,
	input  logic [1:0] policy,
	input  logic [4:0] frames_in_use,
	input  pfr_cmd_t cmd,
	output pfr_sts_t sts,
	output pfr_out_t out_item
);
	localparam int unsigned MapSize = PROCESSES * PAGES_PER_PROCESS;
	localparam int unsigned SlotW   = (MapSize > 1) ? $clog2(MapSize) : 1;
	localparam int unsigned FIdxW   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int unsigned CntW    = $clog2(MAX_FRAMES + 1);

	// effective count
	logic [CntW-1:0] count;
	always_comb begin
		if (frames_in_use == 5'd0) begin
			count = CntW'(1);
		end else if (32'(frames_in_use) > MAX_FRAMES) begin
			count = CntW'(MAX_FRAMES);
		end else begin
			count = CntW'(frames_in_use);
		end
	end

	// latched request
	logic [ProcW-1:0] proc_q;
	logic [PageW-1:0] page_q;
	logic [RndW-1:0]  rem_q;
	logic [4:0]       rem_bit_q;
	logic [SlotW-1:0] slot_q;
	logic [TimeW-1:0] time_q;
	logic [FIdxW-1:0] last_q;
	logic [CntW-1:0]  count_q;

	logic [ProcW-1:0] proc_r;
	logic [PageW-1:0] page_r;
	assign proc_r = ProcW'(32'(in_item.process_id) % PROCESSES);
	assign page_r = PageW'(32'(in_item.page_no) % PAGES_PER_PROCESS);

	logic [SlotW-1:0] slot_d;
	assign slot_d = SlotW'(32'(proc_r) * PAGES_PER_PROCESS + 32'(page_r));

	// frame table (flops: scanned every entry)
	logic                   busy_q  [MAX_FRAMES];
	logic [ProcW-1:0]       owner_q [MAX_FRAMES];
	logic [PageW-1:0]       fpage_q [MAX_FRAMES];
	logic [TimeW-1:0]       luse_q  [MAX_FRAMES];

	// page map: valid bits in flops, frame and load time in RAM
	logic [MapSize-1:0] mvalid_q;
	logic               hit_q;
	logic [FIdxW-1:0]   mframe_rd;
	logic [TimeW-1:0]   ltime_rd;

	logic             map_we;
	logic [SlotW-1:0] ram_raddr;
	logic [SlotW-1:0] vslot;

	// scan
	logic [CntW-1:0]  idx_q;
	logic [FIdxW-1:0] frame_q;
	logic             free_q;
	logic [TimeW-1:0] best_q;
	logic             done_q;
	logic [FIdxW-1:0] idx_f;
	assign idx_f = idx_q[FIdxW-1:0];

	pfr_ram #(.WIDTH(FIdxW), .DEPTH(MapSize)) u_map (
		.clk(clk), .we(map_we), .waddr(slot_q), .wdata(frame_q),
		.raddr(slot_d), .rdata(mframe_rd)
	);
	pfr_ram #(.WIDTH(TimeW), .DEPTH(MapSize)) u_ltime (
		.clk(clk), .we(map_we), .waddr(slot_q), .wdata(time_q),
		.raddr(ram_raddr), .rdata(ltime_rd)
	);

	logic [ProcW-1:0] vproc;
	logic [PageW-1:0] vpage;
	assign vproc = owner_q[frame_q];
	assign vpage = fpage_q[frame_q];
	assign vslot = SlotW'(32'(vproc) * PAGES_PER_PROCESS + 32'(vpage));
	// load time is only needed for the victim; frame_q holds still from the end of
	// victim selection (scan or remainder) to commit, so the read data is settled by then
	assign ram_raddr = vslot;

	assign map_we = cmd.commit && !hit_q;

	// remainder: restoring, one bit a cycle
	logic [CntW:0] rem_try;
	logic [RndW-1:0] rem_sh;
	assign rem_sh  = rem_q;

	// racc_q holds partial remainder
	logic [CntW-1:0] racc_q;
	logic [CntW:0]   racc_sh;
	assign racc_sh = {racc_q, rem_sh[RndW-1]};
	assign rem_try = racc_sh - {1'b0, count_q};

	assign sts.hit        = hit_q;
	assign sts.scan_done  = done_q;
	assign sts.free_found = free_q;
	assign sts.rem_done   = (rem_bit_q == 5'd0);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			proc_q    <= proc_r;
			page_q    <= page_r;
			slot_q    <= slot_d;
			rem_q     <= in_item.random_value;
			rem_bit_q <= 5'(RndW);
			count_q   <= count;
			racc_q    <= '0;
		end
		if (cmd.scan_start) begin
			// one ascending pass: last free frame seen wins, LRU keeps first minimum
			idx_q  <= '0;
			free_q <= 1'b0;
			done_q <= 1'b0;
			best_q <= '1;
			frame_q <= '0;
		end else if (cmd.scan_step) begin
			if (idx_q == count_q) begin
				done_q <= 1'b1;
				if (!free_q) begin
					if (policy == POL_LIFO) begin
						frame_q <= last_q;
					end
				end
			end else begin
				idx_q <= idx_q + 1'b1;
				if (!busy_q[idx_f]) begin
					free_q  <= 1'b1;
					frame_q <= idx_f; // highest free wins (ascending)
				end else if (!free_q && (idx_q == '0 || luse_q[idx_f] < best_q)) begin
					best_q  <= luse_q[idx_f];
					frame_q <= idx_f;
				end
			end
		end else if (cmd.rem_step) begin
			rem_q     <= {rem_q[RndW-2:0], 1'b0};
			rem_bit_q <= rem_bit_q - 1'b1;
			if (!rem_try[CntW]) begin
				racc_q <= rem_try[CntW-1:0];
			end else begin
				racc_q <= racc_sh[CntW-1:0];
			end
			if (rem_bit_q == 5'd1) begin
				frame_q <= rem_try[CntW] ? FIdxW'(racc_sh) : FIdxW'(rem_try);
			end
		end
		if (hit_q && cmd.scan_start == 1'b0 && cmd.commit) begin
			frame_q <= frame_q;
		end
	end

	// map read result for hit, latched in the cycle after load
	logic look_q;
	logic [FIdxW-1:0] hframe_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			look_q <= 1'b0;
			hit_q  <= 1'b0;
		end else begin
			look_q <= cmd.load;
			if (cmd.load) begin
				hit_q <= mvalid_q[slot_d];
			end
		end
	end
	assign hframe_q = mframe_rd;

	logic [FIdxW-1:0] hit_frame_q;
	always_ff @(posedge clk) begin
		if (look_q) begin
			hit_frame_q <= hframe_q;
		end
	end

	logic [FIdxW-1:0] cframe;
	assign cframe = hit_q ? hit_frame_q : frame_q;
	logic evict;
	assign evict = !hit_q && !free_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q   <= '0;
			last_q   <= '0;
			mvalid_q <= '0;
			for (int i = 0; i < MAX_FRAMES; i++) begin
				busy_q[i] <= 1'b0;
			end
		end else begin
			if (cmd.load) begin
				time_q <= time_q + 1'b1;
			end
			if (cmd.commit && !hit_q) begin
				busy_q[cframe] <= 1'b1;
				last_q         <= cframe;
				if (evict) begin
					mvalid_q[vslot] <= 1'b0;
				end
				mvalid_q[slot_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			luse_q[cframe] <= time_q;
			if (!hit_q) begin
				owner_q[cframe] <= proc_q;
				fpage_q[cframe] <= page_q;
			end
			out_item.hit            <= hit_q;
			out_item.frame_index    <= FrameW'(cframe);
			out_item.evicted        <= evict;
			out_item.victim_process <= evict ? 2'(vproc) : 2'd0;
			out_item.victim_page    <= evict ? 6'(vpage) : 6'd0;
			out_item.residency      <= evict ? time_q - ltime_rd : '0;
		end
	end
endmodule

### sv/page_frame_replacement.sv
// Top level of the page frame replacement block.
// Depends on pfr_pkg, pfr_ctrl, pfr_dp, pfr_ram.
//
// channel | direction | handshake          | payload
// in      | input     | in_valid/in_stall  | pfr_in_t
// out     | output    | out_valid/out_stall| pfr_out_t
// cfg     | input     | cfg_valid/cfg_ready| pfr_cfg_t
//
// A hit needs no frame scan. A fault into a free frame adds the frame scan (one
// frame a cycle); an eviction also reads the victim's load time, and random
// replacement adds the bitwise remainder of the random value by the frame count.
// One transaction at a time; input is stalled until the result is taken.
// Reset: policy LRU, 16 frames, all frames free, all pages unmapped.
module page_frame_replacement import pfr_pkg::*; #(
	parameter int unsigned MAX_FRAMES        = 16,
	parameter int unsigned PAGES_PER_PROCESS = 64,
	parameter int unsigned PROCESSES         = 4
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  pfr_in_t  in_data,
	output logic     out_valid,
	input  logic     out_stall,
	output pfr_out_t out_data,
	input  logic     cfg_valid,
	output logic     cfg_ready,
	input  pfr_cfg_t cfg_data
);
	logic [1:0] policy_q;
	logic [4:0] frames_q;
	pfr_cmd_t   cmd;
	pfr_sts_t   sts;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POL_LRU;
			frames_q <= 5'd16;
		end else if (cfg_valid) begin
			if (cfg_data.index == {1'b0, CFG_POLICY}) begin
				policy_q <= cfg_data.data[1:0];
			end else if (cfg_data.index == {1'b0, CFG_FRAMES}) begin
				frames_q <= cfg_data.data;
			end
		end
	end

	pfr_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .policy(policy_q),
		.cmd(cmd), .sts(sts)
	);

	pfr_dp #(
		.MAX_FRAMES(MAX_FRAMES), .PAGES_PER_PROCESS(PAGES_PER_PROCESS),
		.PROCESSES(PROCESSES)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .in_item(in_data), .policy(policy_q),
		.frames_in_use(frames_q), .cmd(cmd), .sts(sts), .out_item(out_data)
	);
endmodule
